@@ sv/rdq_pkg.sv @@
// Shared types and codes for the record deque with key search.
`default_nettype none

package rdq_pkg;

    // operation codes on the request channel
    localparam logic [2:0] FUNC_INS_FRONT = 3'd0;
    localparam logic [2:0] FUNC_INS_BACK  = 3'd1;
    localparam logic [2:0] FUNC_REM_FRONT = 3'd2;
    localparam logic [2:0] FUNC_REM_BACK  = 3'd3;
    localparam logic [2:0] FUNC_SEARCH    = 3'd4;
    localparam logic [2:0] FUNC_CLEAR     = 3'd5;

    // status codes on the response channel
    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;
    localparam logic [1:0] STAT_MISS  = 2'd3;

    localparam int unsigned ENTRY_COUNT_W = 5;

    typedef struct packed {
        logic signed [31:0] key;
        logic [63:0]        name_low;
        logic [15:0]        name_high;
        logic [31:0]        price;
    } record_t;

    // what a cell loads at the next edge
    typedef enum logic [1:0] {
        CELL_HOLD  = 2'd0,
        CELL_NEW   = 2'd1,
        CELL_LEFT  = 2'd2,
        CELL_RIGHT = 2'd3
    } cell_mode_t;

endpackage

`default_nettype wire

@@ sv/rdq_if.sv @@
// Request and response channel interfaces of the record deque.
`default_nettype none

interface rdq_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         func;
    logic signed [31:0] key;
    logic [63:0]        name_low;
    logic [15:0]        name_high;
    logic [31:0]        price_bits;

    modport source (output valid, func, key, name_low, name_high, price_bits, input ready);
    modport sink   (input valid, func, key, name_low, name_high, price_bits, output ready);
endinterface

interface rdq_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] found_key;
    logic [63:0]        found_name_low;
    logic [15:0]        found_name_high;
    logic [31:0]        found_price;
    logic [4:0]         entry_count;

    modport source (output valid, status, found_key, found_name_low, found_name_high,
                    found_price, entry_count, input ready);
    modport sink   (input valid, status, found_key, found_name_low, found_name_high,
                    found_price, entry_count, output ready);
endinterface

`default_nettype wire

@@ sv/rdq_cell.sv @@
// One record cell of the deque chain.
`default_nettype none

module rdq_cell
    import rdq_pkg::*;
(
    input  wire logic       clk,
    input  wire cell_mode_t mode,
    input  wire record_t    new_rec,
    input  wire record_t    left_rec,
    input  wire record_t    right_rec,
    output record_t         rec
);

    record_t rec_reg;

    always_ff @(posedge clk)
    begin
        case (mode)
            CELL_NEW:   rec_reg <= new_rec;
            CELL_LEFT:  rec_reg <= left_rec;
            CELL_RIGHT: rec_reg <= right_rec;
            default:    rec_reg <= rec_reg;
        endcase
    end

    assign rec = rec_reg;

endmodule

`default_nettype wire

@@ sv/record_deque_with_key_search.sv @@
// Top level: bounded record deque built as a chain of cells, with linear key search.
//
// Usage: each request transfer on req carries one operation (insert front, insert
// back, remove front, remove back, search by key, clear) and produces exactly one
// response transfer on rsp with status, the matched record and the count held.
// Records sit in a row of CAPACITY cells in list order, front in cell 0. Inserts
// at the front shift the row right, removals at the front shift it left, inserts
// at the back load the cell at the current count; removals at the back and clear
// only touch the count.
// Timing: insert, remove and clear answer in the cycle after the request transfer.
// A search on a non-empty list rotates the whole row through cell 0 in ST_SCAN,
// comparing one record a cycle, then loads the answer into the output register
// in ST_FINISH; the rotation through the cell ring bounds throughput.
// Sustained rate: one item per cycle for short operations while no response
// waits on rsp.ready; no new request is taken until a search has answered.
// Reset: count and control clear at once, the list is empty; cell contents are
// left as they are, only held cells are ever read.
// Stall: a finished response waits in the output register until rsp.ready; while
// it waits no new request is taken, and a finished search holds its answer.
`default_nettype none

module record_deque_with_key_search
    import rdq_pkg::*;
#(
    parameter int unsigned CAPACITY = 16
)
(
    input wire logic clk,
    input wire logic rst_n,
    rdq_req_if.sink   req,
    rdq_rsp_if.source rsp
);

    localparam int unsigned IDX_W = $clog2(CAPACITY);
    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   step_reg, step_next;
    logic               found_reg, found_next;
    logic               out_valid_reg, out_valid_next;
    logic signed [31:0] key_reg;
    record_t            found_rec_reg;
    logic [1:0]         status_reg;
    record_t            rsp_rec_reg;
    logic [CNT_W-1:0]   rsp_count_reg;

    cell_mode_t         mode [CAPACITY];
    record_t            cell_rec [CAPACITY];
    record_t            new_rec;

    logic               accept;
    logic               slot_free;
    logic               is_full;
    logic               is_empty;
    logic               scan_hit;
    logic               load_out;
    logic               use_found;
    logic [1:0]         status_next;

    assign new_rec = {req.key, req.name_low, req.name_high, req.price_bits};

    // the row of cells: left of cell 0 is the incoming record, right of the
    // last cell wraps to cell 0 so a full rotation restores the order
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            rdq_cell u_cell (
                .clk       (clk),
                .mode      (mode[i]),
                .new_rec   (new_rec),
                .left_rec  (new_rec),
                .right_rec (cell_rec[(i + 1) % CAPACITY]),
                .rec       (cell_rec[i])
            );
        end
        else
        begin : g_rest
            rdq_cell u_cell (
                .clk       (clk),
                .mode      (mode[i]),
                .new_rec   (new_rec),
                .left_rec  (cell_rec[i - 1]),
                .right_rec (cell_rec[(i + 1) % CAPACITY]),
                .rec       (cell_rec[i])
            );
        end
    end

    assign slot_free = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE) && slot_free;
    assign accept    = req.valid && req.ready;
    assign is_full   = (count_reg == CNT_W'(CAPACITY));
    assign is_empty  = (count_reg == '0);

    // cell 0 holds list position step_reg during a scan; take the first hit
    assign scan_hit = !found_reg && (CNT_W'(step_reg) < count_reg)
                      && (cell_rec[0].key == key_reg);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        step_next   = step_reg;
        found_next  = found_reg;
        load_out    = 1'b0;
        use_found   = 1'b0;
        status_next = STAT_DONE;
        for (int i = 0; i < CAPACITY; i++)
        begin
            mode[i] = CELL_HOLD;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    load_out = 1'b1;
                    case (req.func)
                        FUNC_INS_FRONT:
                        begin
                            if (is_full)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                for (int i = 0; i < CAPACITY; i++)
                                begin
                                    mode[i] = CELL_LEFT;
                                end
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        FUNC_INS_BACK:
                        begin
                            if (is_full)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                for (int i = 0; i < CAPACITY; i++)
                                begin
                                    if (IDX_W'(i) == count_reg[IDX_W-1:0])
                                    begin
                                        mode[i] = CELL_NEW;
                                    end
                                end
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        FUNC_REM_FRONT:
                        begin
                            if (is_empty)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                for (int i = 0; i < CAPACITY; i++)
                                begin
                                    mode[i] = CELL_RIGHT;
                                end
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        FUNC_REM_BACK:
                        begin
                            if (is_empty)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        FUNC_SEARCH:
                        begin
                            if (is_empty)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                // answer comes from the scan instead
                                load_out   = 1'b0;
                                state_next = ST_SCAN;
                                step_next  = '0;
                                found_next = 1'b0;
                            end
                        end
                        FUNC_CLEAR:
                        begin
                            if (is_empty)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                count_next = '0;
                            end
                        end
                        default:
                        begin
                            status_next = STAT_DONE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // rotate the row one cell toward the front each cycle
                for (int i = 0; i < CAPACITY; i++)
                begin
                    mode[i] = CELL_RIGHT;
                end
                if (scan_hit)
                begin
                    found_next = 1'b1;
                end
                step_next = step_reg + IDX_W'(1);
                if (step_reg == IDX_W'(CAPACITY - 1))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    load_out    = 1'b1;
                    use_found   = found_reg;
                    status_next = found_reg ? STAT_DONE : STAT_MISS;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = load_out ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            step_reg      <= step_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers: capture search key, first hit and the response
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg <= req.key;
        end
        if (state_reg == ST_SCAN && scan_hit)
        begin
            found_rec_reg <= cell_rec[0];
        end
        if (load_out)
        begin
            status_reg    <= status_next;
            rsp_rec_reg   <= use_found ? found_rec_reg : '0;
            rsp_count_reg <= count_next;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = status_reg;
    assign rsp.found_key       = rsp_rec_reg.key;
    assign rsp.found_name_low  = rsp_rec_reg.name_low;
    assign rsp.found_name_high = rsp_rec_reg.name_high;
    assign rsp.found_price     = rsp_rec_reg.price;
    assign rsp.entry_count     = ENTRY_COUNT_W'(rsp_count_reg);

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("held count above capacity");

    a_scan_blocks_req: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !req.ready)
        else $error("request taken during a search");

    a_scan_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && step_reg != IDX_W'(CAPACITY - 1))
        |=> (state_reg == ST_SCAN && step_reg == $past(step_reg) + IDX_W'(1)))
        else $error("scan step did not advance");

    a_search_answers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && slot_free) |=> (rsp.valid && state_reg == ST_IDLE))
        else $error("finished search gave no response");
`endif

endmodule

`default_nettype wire
